FILE: src/rmq_pkg.sv
`timescale 1ns / 1ps
package rmq_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;
  localparam int MID_DEPTH      = 2;   // front-to-back queue
  localparam int OUT_DEPTH      = 2;   // result queue
  localparam int NLANES         = 3;   // scaled components per item

  // Output slot that takes the half root; the other three are divider lanes
  typedef enum logic [1:0] {
    SLOT_W,
    SLOT_X,
    SLOT_Y,
    SLOT_Z
  } slot_e;

  typedef struct packed {
    logic en;      // pipeline advance
    logic valid;   // item entering stage 0
  } pipe_ctl_t;

endpackage

FILE: src/rmq_fifo.sv
`timescale 1ns / 1ps
module rmq_fifo #(
  parameter int DW    = 8,
  parameter int DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] din_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic [DW-1:0] dout_o,
  output logic          empty_o
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [DW-1:0]   mem_q [DEPTH];
  logic [PTRW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign dout_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTRW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTRW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= din_i;
    end
  end

endmodule

FILE: src/rmq_front.sv
`timescale 1ns / 1ps
module rmq_front #(
  parameter int W  = 16,
  parameter int F  = 14,
  parameter int AW = 19,
  parameter int MW = 17
) (
  input  logic signed [W-1:0] m00_i,
  input  logic signed [W-1:0] m01_i,
  input  logic signed [W-1:0] m02_i,
  input  logic signed [W-1:0] m10_i,
  input  logic signed [W-1:0] m11_i,
  input  logic signed [W-1:0] m12_i,
  input  logic signed [W-1:0] m20_i,
  input  logic signed [W-1:0] m21_i,
  input  logic signed [W-1:0] m22_i,
  output logic [AW-2:0]       rad_o,
  output rmq_pkg::slot_e      sel_o,
  output logic [MW-1:0]       mag_o [rmq_pkg::NLANES],
  output logic                neg_o [rmq_pkg::NLANES]
);
  import rmq_pkg::*;

  function automatic logic signed [W:0] ext(input logic signed [W-1:0] v);
    return {v[W-1], v};
  endfunction

  logic signed [AW-1:0] d [3];
  logic signed [AW-1:0] trace, one, a;
  logic signed [W:0]    v [NLANES];
  logic [1:0]           idx;
  logic                 pos;

  always_comb begin
    d[0]  = AW'(m00_i);
    d[1]  = AW'(m11_i);
    d[2]  = AW'(m22_i);
    one   = AW'(1) <<< F;
    trace = d[0] + d[1] + d[2];
    pos   = (trace > 0);
    idx   = 2'd0;
    if (d[1] > d[0]) idx = 2'd1;
    if (d[2] > d[idx]) idx = 2'd2;

    // lanes hold the non-root slots in ascending slot order
    if (pos) begin
      sel_o = SLOT_W;
      a     = trace + one;
      v[0]  = ext(m21_i) - ext(m12_i);
      v[1]  = ext(m02_i) - ext(m20_i);
      v[2]  = ext(m10_i) - ext(m01_i);
    end else begin
      unique case (idx)
        2'd1: begin
          sel_o = SLOT_Y;
          a     = d[1] - (d[2] + d[0]) + one;
          v[0]  = ext(m02_i) - ext(m20_i);
          v[1]  = ext(m01_i) + ext(m10_i);
          v[2]  = ext(m21_i) + ext(m12_i);
        end
        2'd2: begin
          sel_o = SLOT_Z;
          a     = d[2] - (d[0] + d[1]) + one;
          v[0]  = ext(m10_i) - ext(m01_i);
          v[1]  = ext(m02_i) + ext(m20_i);
          v[2]  = ext(m12_i) + ext(m21_i);
        end
        default: begin
          sel_o = SLOT_X;
          a     = d[0] - (d[1] + d[2]) + one;
          v[0]  = ext(m21_i) - ext(m12_i);
          v[1]  = ext(m10_i) + ext(m01_i);
          v[2]  = ext(m20_i) + ext(m02_i);
        end
      endcase
    end

    rad_o = (a > 0) ? a[AW-2:0] : '0;   // negative argument clamps to zero
    for (int l = 0; l < NLANES; l++) begin
      neg_o[l] = v[l][W];
      mag_o[l] = v[l][W] ? MW'(-v[l]) : MW'(v[l]);
    end
  end

endmodule

FILE: src/rmq_sqrt.sv
`timescale 1ns / 1ps
module rmq_sqrt #(
  parameter int RW = 16,
  parameter int PW = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rmq_pkg::pipe_ctl_t  ctl_i,
  input  logic [2*RW-1:0]     rad_i,
  input  logic [PW-1:0]       pay_i,
  output logic                valid_o,
  output logic [RW-1:0]       root_o,
  output logic [PW-1:0]       pay_o
);
  import rmq_pkg::*;

  // one root bit per stage
  logic            vld_q  [RW];
  logic [2*RW-1:0] rad_q  [RW];
  logic [RW+1:0]   rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [PW-1:0]   pay_q  [RW];

  for (genvar s = 0; s < RW; s++) begin : g_stg
    logic            vld_p;
    logic [2*RW-1:0] rad_p;
    logic [RW+1:0]   rem_p;
    logic [RW-1:0]   root_p;
    logic [PW-1:0]   pay_p;
    logic [RW+3:0]   rem_in, trial, rem_d;
    logic            ge;

    if (s == 0) begin : g_first
      assign vld_p  = ctl_i.valid;
      assign rad_p  = rad_i;
      assign rem_p  = '0;
      assign root_p = '0;
      assign pay_p  = pay_i;
    end else begin : g_next
      assign vld_p  = vld_q[s-1];
      assign rad_p  = rad_q[s-1];
      assign rem_p  = rem_q[s-1];
      assign root_p = root_q[s-1];
      assign pay_p  = pay_q[s-1];
    end

    assign rem_in = {rem_p, rad_p[2*RW-1 -: 2]};
    assign trial  = {2'b00, root_p, 2'b01};
    assign ge     = (rem_in >= trial);
    // remainder never exceeds twice the partial root
    assign rem_d  = ge ? (rem_in - trial) : rem_in;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[s] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rad_q[s]  <= rad_p << 2;
        rem_q[s]  <= rem_d[RW+1:0];
        root_q[s] <= {root_p[RW-2:0], ge};
        pay_q[s]  <= pay_p;
      end
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign pay_o   = pay_q[RW-1];

endmodule

FILE: src/rmq_div.sv
`timescale 1ns / 1ps
module rmq_div #(
  parameter int W  = 16,
  parameter int F  = 14,
  parameter int RW = 16,
  parameter int MW = 17,
  parameter int CW = 32,
  parameter int PW = 18
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rmq_pkg::pipe_ctl_t ctl_i,
  input  logic [RW-1:0]      root_i,
  input  logic [MW-1:0]      mag_i [rmq_pkg::NLANES],
  input  logic               neg_i [rmq_pkg::NLANES],
  input  logic [PW-1:0]      pay_i,
  output logic               valid_o,
  output logic [W-1:0]       quo_o [rmq_pkg::NLANES],
  output logic [PW-1:0]      pay_o
);
  import rmq_pkg::*;

  // stage 0: numerator, divisor, overflow; then one quotient bit per stage
  localparam int STG = W;

  logic          vld_q [STG];
  logic [PW-1:0] pay_q [STG];
  logic [CW-1:0] rem_q [STG][NLANES];
  logic [CW-1:0] dv_q  [STG][NLANES];
  logic          ovf_q [STG][NLANES];
  logic          neg_q [STG][NLANES];
  logic [W-2:0]  q_q   [STG][NLANES];

  for (genvar s = 0; s < STG; s++) begin : g_stg
    logic vld_p;
    logic [PW-1:0] pay_p;

    if (s == 0) begin : g_first
      assign vld_p = ctl_i.valid;
      assign pay_p = pay_i;
    end else begin : g_next
      assign vld_p = vld_q[s-1];
      assign pay_p = pay_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[s] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        pay_q[s] <= pay_p;
      end
    end

    for (genvar l = 0; l < NLANES; l++) begin : g_lane
      if (s == 0) begin : g_first
        logic [CW-1:0] num, dv;
        assign num = (CW'(mag_i[l]) << F) + CW'(root_i);
        assign dv  = CW'(root_i) << 1;
        always_ff @(posedge clk_i) begin
          if (ctl_i.en) begin
            rem_q[s][l] <= num;
            dv_q[s][l]  <= dv;
            ovf_q[s][l] <= (num >= (dv << (W - 1)));
            neg_q[s][l] <= neg_i[l];
            q_q[s][l]   <= '0;
          end
        end
      end else begin : g_next
        localparam int B = W - 1 - s;
        logic [CW-1:0] sub;
        logic          ge;
        assign sub = dv_q[s-1][l] << B;
        assign ge  = (rem_q[s-1][l] >= sub);
        always_ff @(posedge clk_i) begin
          if (ctl_i.en) begin
            rem_q[s][l] <= ge ? (rem_q[s-1][l] - sub) : rem_q[s-1][l];
            dv_q[s][l]  <= dv_q[s-1][l];
            ovf_q[s][l] <= ovf_q[s-1][l];
            neg_q[s][l] <= neg_q[s-1][l];
            q_q[s][l]   <= q_q[s-1][l] | ((W-1)'(ge) << B);
          end
        end
      end
    end
  end

  // zero root gives zero, overflow saturates toward the sign
  always_comb begin
    logic [W-1:0] qx;
    for (int l = 0; l < NLANES; l++) begin
      qx = {1'b0, q_q[STG-1][l]};
      if (dv_q[STG-1][l] == '0) begin
        quo_o[l] = '0;
      end else if (ovf_q[STG-1][l]) begin
        quo_o[l] = neg_q[STG-1][l] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        quo_o[l] = neg_q[STG-1][l] ? (~qx + 1'b1) : qx;
      end
    end
  end

  assign valid_o = vld_q[STG-1];
  assign pay_o   = pay_q[STG-1];

endmodule

FILE: src/rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps
// An accepted beat passes the front queue, the root pipe and the divider pipe
//   into the result queue; RW = ceil((AW - 1 + FRAC_BITS) / 2) root bits.
// Throughput: one matrix per cycle; the root and divider pipes take a beat
//   every cycle unless a finished beat finds the result queue full.
// Reset: rst_ni asynchronous, active low; empties both queues and the pipes.
module rotation_matrix_to_quaternion #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic signed [DATA_WIDTH-1:0] m00_i,
  input  logic signed [DATA_WIDTH-1:0] m01_i,
  input  logic signed [DATA_WIDTH-1:0] m02_i,
  input  logic signed [DATA_WIDTH-1:0] m10_i,
  input  logic signed [DATA_WIDTH-1:0] m11_i,
  input  logic signed [DATA_WIDTH-1:0] m12_i,
  input  logic signed [DATA_WIDTH-1:0] m20_i,
  input  logic signed [DATA_WIDTH-1:0] m21_i,
  input  logic signed [DATA_WIDTH-1:0] m22_i,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [DATA_WIDTH-1:0] quat_w_o,
  output logic signed [DATA_WIDTH-1:0] quat_x_o,
  output logic signed [DATA_WIDTH-1:0] quat_y_o,
  output logic signed [DATA_WIDTH-1:0] quat_z_o
);
  import rmq_pkg::*;

  localparam int W    = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  // root argument: trace plus one, signed, with headroom
  localparam int AW   = ((W > F) ? W : F + 1) + 3;
  localparam int RDW  = AW - 1 + F;              // radicand bits
  localparam int RW   = (RDW + 1) / 2;           // root bits
  localparam int MW   = W + 1;                   // |difference| bits
  localparam int NW   = ((MW + F > RW) ? MW + F : RW) + 1;
  localparam int CW   = (NW > RW + W) ? NW : RW + W;
  localparam int LW   = MW + 1;                  // one lane: sign + magnitude
  localparam int SPW  = 2 + NLANES * LW;         // carried through the root pipe
  localparam int MIDW = AW - 1 + SPW;
  localparam int DPW  = 2 + W;                   // slot and half root
  localparam int HW   = RW + W;

  // ---------------- front: classify and form root argument ----------------
  logic [AW-2:0] f_rad;
  slot_e         f_sel;
  logic [MW-1:0] f_mag [NLANES];
  logic          f_neg [NLANES];
  logic [MIDW-1:0] mid_din, mid_dout;
  logic          mid_empty, mid_pop;

  rmq_front #(.W(W), .F(F), .AW(AW), .MW(MW)) u_front (
    .m00_i, .m01_i, .m02_i, .m10_i, .m11_i, .m12_i, .m20_i, .m21_i, .m22_i,
    .rad_o (f_rad),
    .sel_o (f_sel),
    .mag_o (f_mag),
    .neg_o (f_neg)
  );

  always_comb begin
    mid_din = '0;
    mid_din[MIDW-1 -: AW-1] = f_rad;
    mid_din[SPW-1 -: 2]     = f_sel;
    for (int l = 0; l < NLANES; l++) begin
      mid_din[l*LW +: LW] = {f_neg[l], f_mag[l]};
    end
  end

  // short queue decouples the front from the arithmetic pipes
  rmq_fifo #(.DW(MIDW), .DEPTH(MID_DEPTH)) u_mid (
    .clk_i, .rst_ni,
    .push_i  (push),
    .din_i   (mid_din),
    .full_o  (full),
    .pop_i   (mid_pop),
    .dout_o  (mid_dout),
    .empty_o (mid_empty)
  );

  // ---------------- back: root pipe, divider pipe ----------------
  pipe_ctl_t     sq_ctl, dv_ctl;
  logic          en, sq_valid, dv_valid, out_full;
  logic [2*RW-1:0] sq_rad;
  logic [RW-1:0] sq_root;
  logic [SPW-1:0] sq_pay;
  logic [MW-1:0] d_mag [NLANES];
  logic          d_neg [NLANES];
  logic [HW-1:0] hr_ext;
  logic [W-1:0]  hroot;
  logic [DPW-1:0] dv_pay_in, dv_pay;
  logic [W-1:0]  quo [NLANES];

  // whole back end holds only when a finished beat cannot enter the queue
  assign en      = !(dv_valid && out_full);
  assign mid_pop = en && !mid_empty;

  assign sq_ctl.en    = en;
  assign sq_ctl.valid = !mid_empty;
  assign sq_rad       = (2*RW)'(mid_dout[MIDW-1 -: AW-1]) << F;

  rmq_sqrt #(.RW(RW), .PW(SPW)) u_sqrt (
    .clk_i, .rst_ni,
    .ctl_i   (sq_ctl),
    .rad_i   (sq_rad),
    .pay_i   (mid_dout[SPW-1:0]),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .pay_o   (sq_pay)
  );

  // half root rounded up, saturated to the positive range
  always_comb begin
    hr_ext = (HW'(sq_root) + 1'b1) >> 1;
    if (hr_ext > HW'({1'b0, {(W-1){1'b1}}})) begin
      hroot = {1'b0, {(W-1){1'b1}}};
    end else begin
      hroot = hr_ext[W-1:0];
    end
    for (int l = 0; l < NLANES; l++) begin
      d_neg[l] = sq_pay[l*LW + MW];
      d_mag[l] = sq_pay[l*LW +: MW];
    end
    dv_pay_in = {sq_pay[SPW-1 -: 2], hroot};
  end

  assign dv_ctl.en    = en;
  assign dv_ctl.valid = sq_valid;

  rmq_div #(.W(W), .F(F), .RW(RW), .MW(MW), .CW(CW), .PW(DPW)) u_div (
    .clk_i, .rst_ni,
    .ctl_i   (dv_ctl),
    .root_i  (sq_root),
    .mag_i   (d_mag),
    .neg_i   (d_neg),
    .pay_i   (dv_pay_in),
    .valid_o (dv_valid),
    .quo_o   (quo),
    .pay_o   (dv_pay)
  );

  // ---------------- slot assembly and result queue ----------------
  slot_e          o_sel;
  logic [W-1:0]   o_hr, o_w, o_x, o_y, o_z;
  logic [4*W-1:0] out_din, out_dout;

  always_comb begin
    o_sel = slot_e'(dv_pay[DPW-1 -: 2]);
    o_hr  = dv_pay[W-1:0];
    // lanes fill the three slots that do not take the root, in order
    o_w = (o_sel == SLOT_W) ? o_hr : quo[0];
    o_x = (o_sel == SLOT_X) ? o_hr : ((o_sel == SLOT_W) ? quo[0] : quo[1]);
    o_y = (o_sel == SLOT_Y) ? o_hr : ((o_sel == SLOT_Z) ? quo[2] : quo[1]);
    o_z = (o_sel == SLOT_Z) ? o_hr : quo[2];
    out_din = {o_w, o_x, o_y, o_z};
  end

  rmq_fifo #(.DW(4*W), .DEPTH(OUT_DEPTH)) u_out (
    .clk_i, .rst_ni,
    .push_i  (dv_valid),
    .din_i   (out_din),
    .full_o  (out_full),
    .pop_i   (pop),
    .dout_o  (out_dout),
    .empty_o (empty)
  );

  assign quat_w_o = out_dout[4*W-1 -: W];
  assign quat_x_o = out_dout[3*W-1 -: W];
  assign quat_y_o = out_dout[2*W-1 -: W];
  assign quat_z_o = out_dout[W-1:0];

endmodule

FILE: src/rmq_chk.sv
`timescale 1ns / 1ps
module rmq_chk #(
  parameter int W = 16
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                push,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input logic signed [W-1:0] quat_w_o,
  input logic signed [W-1:0] quat_x_o,
  input logic signed [W-1:0] quat_y_o,
  input logic signed [W-1:0] quat_z_o
);

  logic [7:0] cnt_q;   // beats accepted but not yet delivered
  logic       acc_in, acc_out;

  assign acc_in  = push && !full;
  assign acc_out = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + 8'(acc_in) - 8'(acc_out);
    end
  end

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> cnt_q != '0)
    else $error("result shown with nothing outstanding");

  a_full_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> cnt_q != '0)
    else $error("full with nothing outstanding");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(quat_w_o) && $stable(quat_x_o)
                          && $stable(quat_y_o) && $stable(quat_z_o)))
    else $error("stalled result changed");

endmodule

bind rotation_matrix_to_quaternion rmq_chk #(.W(DATA_WIDTH)) u_chk (.*);
